>>> rtl/fbwpa_pkg.sv
// Shared types and constants of the flash block write-pointer allocator.
// Used by the bitmap store, the byte scanner and the top level.
`default_nettype none

package fbwpa_pkg;

  // Default geometry of the flash array
  localparam int NUM_BLOCKS_DEF      = 4096;
  localparam int RESERVED_BLOCKS_DEF = 8;
  localparam int PAGES_PER_BLOCK_DEF = 64;

  // Fixed field widths of the item and result channels
  localparam int FUNC_W     = 2;
  localparam int IDX_W      = 9;
  localparam int BYTE_W     = 8;
  localparam int BLK_OUT_W  = 12;
  localparam int PAGE_OUT_W = 6;

  // Item function codes
  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD   = 2'd0,
    FN_LOCATE = 2'd1,
    FN_OPEN   = 2'd2,
    FN_APPEND = 2'd3
  } func_t;

  // Per-block predicate that the scanner tests
  typedef enum logic [1:0] {
    PRED_FREE  = 2'd0,
    PRED_USED  = 2'd1,
    PRED_VALID = 2'd2
  } pred_t;

  // Scan launch from the sequencer
  typedef struct packed {
    logic  go;
    logic  bwd;
    pred_t pred;
  } scan_cmd_t;

  // Scan completion back to the sequencer
  typedef struct packed {
    logic done;
    logic found;
  } scan_sts_t;

endpackage

`default_nettype wire

>>> rtl/flash_block_write_pointer_allocator.sv
// Load writes both maps and answers; open/append read and mark the block, then scan for the
// next valid block when the pointer moves to a new block; locate runs a series of scans.
// The byte scanner reads one bitmap byte (eight blocks) per cycle.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: synchronous, active low; then a clearing pass over all NUM_BLOCKS/8 map bytes (512)
// sets the free map to all ones with in_ready low. Uses fbwpa_pkg, fbwpa_maps, fbwpa_scan.
`default_nettype none

module flash_block_write_pointer_allocator
  import fbwpa_pkg::*;
#(
  parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
  parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF,
  parameter int PAGES_PER_BLOCK = PAGES_PER_BLOCK_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FUNC_W-1:0]     in_func,
  input  wire logic [IDX_W-1:0]      in_byte_index,
  input  wire logic [BYTE_W-1:0]     in_health_byte,
  input  wire logic [BYTE_W-1:0]     in_written_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [BLK_OUT_W-1:0]  out_write_block,
  output logic      [PAGE_OUT_W-1:0] out_write_page,
  output logic      [BLK_OUT_W-1:0]  out_first_block,
  output logic      [BLK_OUT_W-1:0]  out_last_block,
  output logic                       out_status
);

  localparam int BW        = $clog2(NUM_BLOCKS);
  localparam int AW        = BW - 3;
  localparam int XW        = BW + 2;
  localparam int PW        = $clog2(PAGES_PER_BLOCK);
  localparam int MAP_BYTES = (NUM_BLOCKS + 7) / 8;
  localparam int FALLBACK  = (RESERVED_BLOCKS > 0) ? RESERVED_BLOCKS - 1 : 0;

  localparam logic [BW-1:0] LAST_BLK  = BW'(NUM_BLOCKS - 1);
  localparam logic [BW-1:0] RES_BLK   = BW'(RESERVED_BLOCKS);
  localparam logic [BW-1:0] FB_BLK    = BW'(FALLBACK);
  localparam logic [PW-1:0] LAST_PAGE = PW'(PAGES_PER_BLOCK - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);
  localparam logic [XW-1:0] X_RES     = XW'(RESERVED_BLOCKS);
  localparam logic [XW-1:0] X_LAST    = XW'(NUM_BLOCKS - 1);

  typedef enum logic [15:0] {
    S_CLEAR   = 16'h0001,
    S_IDLE    = 16'h0002,
    S_LOC_RD  = 16'h0004,
    S_LOC_CHK = 16'h0008,
    S_LOC_A   = 16'h0010,
    S_LOC_B1  = 16'h0020,
    S_LOC_B2  = 16'h0040,
    S_LOC_B3  = 16'h0080,
    S_LOC_E   = 16'h0100,
    S_LOC_E1  = 16'h0200,
    S_LOC_E2  = 16'h0400,
    S_MRK_RD  = 16'h0800,
    S_MRK_WR  = 16'h1000,
    S_ADV1    = 16'h2000,
    S_ADV2    = 16'h4000,
    S_RESP    = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [BW-1:0] start_r, start_nxt;
  logic [BW-1:0] end_r, end_nxt;
  logic [BW-1:0] cur_block_r, cur_block_nxt;
  logic [PW-1:0] cur_page_r, cur_page_nxt;
  logic [BW-1:0] tmp_r, tmp_nxt;
  logic          used_r, used_nxt;
  logic [BW-1:0] res_blk_r, res_blk_nxt;
  logic [PW-1:0] res_pg_r, res_pg_nxt;
  logic          res_status_r, res_status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [BLK_OUT_W-1:0]  out_blk_r, out_blk_nxt;
  logic [PAGE_OUT_W-1:0] out_pg_r, out_pg_nxt;
  logic [BLK_OUT_W-1:0]  out_first_r, out_first_nxt;
  logic [BLK_OUT_W-1:0]  out_last_r, out_last_nxt;
  logic                  out_status_r, out_status_nxt;

  // Bitmap store ports
  logic [AW-1:0]     mem_raddr;
  logic [AW-1:0]     mem_waddr;
  logic              we_health;
  logic              we_free;
  logic [BYTE_W-1:0] wd_free;
  logic [BYTE_W-1:0] rd_health;
  logic [BYTE_W-1:0] rd_free;

  // Scanner ports
  scan_cmd_t     scan_cmd;
  scan_sts_t     scan_sts;
  logic [XW-1:0] scan_lo;
  logic [XW-1:0] scan_hi;
  logic [AW-1:0] scan_raddr;
  logic [BW-1:0] scan_blk;

  logic [BYTE_W-1:0] keep;
  logic              is_open;
  logic              open_full;
  logic              loc_fin;
  logic [BW-1:0]     loc_end;

  fbwpa_maps #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_maps (
    .clk      (clk),
    .raddr    (mem_raddr),
    .rd_health(rd_health),
    .rd_free  (rd_free),
    .waddr    (mem_waddr),
    .we_health(we_health),
    .we_free  (we_free),
    .wd_health(in_health_byte),
    .wd_free  (wd_free)
  );

  fbwpa_scan #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (scan_cmd),
    .lo       (scan_lo),
    .hi       (scan_hi),
    .rd_health(rd_health),
    .rd_free  (rd_free),
    .raddr    (scan_raddr),
    .sts      (scan_sts),
    .blk      (scan_blk)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_write_block = out_blk_r;
  assign out_write_page  = out_pg_r;
  assign out_first_block = out_first_r;
  assign out_last_block  = out_last_r;
  assign out_status      = out_status_r;

  // Drop the written bit of reserved blocks on load
  always_comb begin
    for (int k = 0; k < BYTE_W; k++) begin
      keep[k] = (32'({in_byte_index, 3'(k)}) >= RESERVED_BLOCKS);
    end
  end

  assign is_open   = (func_t'(in_func) == FN_OPEN);
  assign open_full = is_open && (cur_block_r == end_r);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    cur_block_nxt  = cur_block_r;
    cur_page_nxt   = cur_page_r;
    tmp_nxt        = tmp_r;
    used_nxt       = used_r;
    res_blk_nxt    = res_blk_r;
    res_pg_nxt     = res_pg_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_blk_nxt    = out_blk_r;
    out_pg_nxt     = out_pg_r;
    out_first_nxt  = out_first_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    mem_raddr      = scan_raddr;
    mem_waddr      = cur_block_r[BW-1:3];
    we_health      = 1'b0;
    we_free        = 1'b0;
    wd_free        = ~(in_health_byte & in_written_byte & keep);
    scan_cmd.go    = 1'b0;
    scan_cmd.bwd   = 1'b0;
    scan_cmd.pred  = PRED_VALID;
    scan_lo        = X_RES;
    scan_hi        = X_LAST;
    loc_fin        = 1'b0;
    loc_end        = start_r;

    unique case (state_r)
      // Set every free bit, one byte a cycle
      S_CLEAR: begin
        we_free      = 1'b1;
        mem_waddr    = clr_addr_r;
        wd_free      = '1;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          unique case (func_t'(in_func))
            FN_LOAD: begin
              if (32'(in_byte_index) < MAP_BYTES) begin
                mem_waddr = AW'(in_byte_index);
                we_health = 1'b1;
                we_free   = 1'b1;
              end
              res_blk_nxt    = cur_block_r;
              res_pg_nxt     = cur_page_r;
              res_status_nxt = 1'b0;
              state_nxt      = S_RESP;
            end
            FN_LOCATE: begin
              state_nxt = S_LOC_RD;
            end
            FN_OPEN, FN_APPEND: begin
              // Open restarts the page unless the pointer sits at the region end
              res_blk_nxt    = cur_block_r;
              res_status_nxt = open_full;
              if (is_open && !open_full) begin
                cur_page_nxt = '0;
                res_pg_nxt   = '0;
              end else begin
                res_pg_nxt = cur_page_r;
              end
              state_nxt = S_MRK_RD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // Look at the free bit of the last block
      S_LOC_RD: begin
        mem_raddr = LAST_BLK[BW-1:3];
        state_nxt = S_LOC_CHK;
      end

      S_LOC_CHK: begin
        scan_cmd.go = 1'b1;
        if (!rd_free[LAST_BLK[2:0]]) begin
          scan_cmd.pred = PRED_FREE;
          state_nxt     = S_LOC_A;
        end else begin
          scan_cmd.bwd  = 1'b1;
          scan_cmd.pred = PRED_USED;
          state_nxt     = S_LOC_B1;
        end
      end

      // Start at the first free block
      S_LOC_A: begin
        if (scan_sts.done) begin
          start_nxt = scan_sts.found ? scan_blk : LAST_BLK;
          state_nxt = S_LOC_E;
        end
      end

      // Highest used block found: search valid blocks after it
      S_LOC_B1: begin
        if (scan_sts.done) begin
          scan_cmd.go = 1'b1;
          used_nxt    = scan_sts.found;
          tmp_nxt     = scan_blk;
          if (scan_sts.found) begin
            scan_lo   = {2'b00, scan_blk} + XW'(1);
            state_nxt = S_LOC_B2;
          end else begin
            state_nxt = S_LOC_B3;
          end
        end
      end

      // Wrap around to the blocks before the highest used one
      S_LOC_B2: begin
        if (scan_sts.done) begin
          if (scan_sts.found) begin
            start_nxt = scan_blk;
            state_nxt = S_LOC_E;
          end else begin
            scan_cmd.go = 1'b1;
            scan_hi     = {2'b00, tmp_r} - XW'(1);
            state_nxt   = S_LOC_B3;
          end
        end
      end

      S_LOC_B3: begin
        if (scan_sts.done) begin
          if (scan_sts.found) begin
            start_nxt = scan_blk;
          end else begin
            start_nxt = used_r ? tmp_r : FB_BLK;
          end
          state_nxt = S_LOC_E;
        end
      end

      // End: last valid block on one lap after the start
      S_LOC_E: begin
        scan_cmd.go  = 1'b1;
        scan_cmd.bwd = 1'b1;
        if (start_r >= RES_BLK) begin
          scan_hi   = {2'b00, start_r} - XW'(1);
          state_nxt = S_LOC_E1;
        end else begin
          state_nxt = S_LOC_E2;
        end
      end

      S_LOC_E1: begin
        if (scan_sts.done) begin
          if (scan_sts.found) begin
            loc_fin = 1'b1;
            loc_end = scan_blk;
          end else begin
            scan_cmd.go  = 1'b1;
            scan_cmd.bwd = 1'b1;
            scan_lo      = {2'b00, start_r} + XW'(1);
            state_nxt    = S_LOC_E2;
          end
        end
      end

      S_LOC_E2: begin
        if (scan_sts.done) begin
          loc_fin = 1'b1;
          loc_end = scan_sts.found ? scan_blk : start_r;
        end
      end

      // Read the free byte of the current block
      S_MRK_RD: begin
        mem_raddr = cur_block_r[BW-1:3];
        state_nxt = S_MRK_WR;
      end

      // Mark the block used, then advance the page or the block
      S_MRK_WR: begin
        we_free = 1'b1;
        wd_free = rd_free & ~(BYTE_W'(1) << cur_block_r[2:0]);
        if (cur_page_r == LAST_PAGE) begin
          cur_page_nxt = '0;
          scan_cmd.go  = 1'b1;
          if (cur_block_r >= RES_BLK) begin
            scan_lo   = {2'b00, cur_block_r} + XW'(1);
            state_nxt = S_ADV1;
          end else begin
            state_nxt = S_ADV2;
          end
        end else begin
          cur_page_nxt = cur_page_r + PW'(1);
          state_nxt    = S_RESP;
        end
      end

      S_ADV1: begin
        if (scan_sts.done) begin
          if (scan_sts.found) begin
            cur_block_nxt = scan_blk;
            state_nxt     = S_RESP;
          end else begin
            scan_cmd.go = 1'b1;
            scan_hi     = {2'b00, cur_block_r} - XW'(1);
            state_nxt   = S_ADV2;
          end
        end
      end

      S_ADV2: begin
        if (scan_sts.done) begin
          if (scan_sts.found) begin
            cur_block_nxt = scan_blk;
          end else begin
            res_status_nxt = 1'b1;
          end
          state_nxt = S_RESP;
        end
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_blk_nxt    = BLK_OUT_W'(res_blk_r);
          out_pg_nxt     = PAGE_OUT_W'(res_pg_r);
          out_first_nxt  = BLK_OUT_W'(start_r);
          out_last_nxt   = BLK_OUT_W'(end_r);
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Close a locate: place the pointer at the start of the region
    if (loc_fin) begin
      end_nxt        = loc_end;
      cur_block_nxt  = start_r;
      cur_page_nxt   = '0;
      res_blk_nxt    = start_r;
      res_pg_nxt     = '0;
      res_status_nxt = (start_r == loc_end);
      state_nxt      = S_RESP;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      start_r     <= '0;
      end_r       <= '0;
      cur_block_r <= '0;
      cur_page_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      cur_block_r <= cur_block_nxt;
      cur_page_r  <= cur_page_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    tmp_r        <= tmp_nxt;
    used_r       <= used_nxt;
    res_blk_r    <= res_blk_nxt;
    res_pg_r     <= res_pg_nxt;
    res_status_r <= res_status_nxt;
    out_blk_r    <= out_blk_nxt;
    out_pg_r     <= out_pg_nxt;
    out_first_r  <= out_first_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/fbwpa_maps.sv
// Healthy and free bitmaps, one byte (eight blocks) per entry.
// One shared write address, one registered read port. Uses fbwpa_pkg.
`default_nettype none

module fbwpa_maps
  import fbwpa_pkg::*;
#(
  parameter int  NUM_BLOCKS = NUM_BLOCKS_DEF,
  localparam int MAP_BYTES  = (NUM_BLOCKS + 7) / 8,
  localparam int AW         = $clog2(NUM_BLOCKS) - 3
) (
  input  wire logic              clk,
  input  wire logic [AW-1:0]     raddr,
  output logic      [BYTE_W-1:0] rd_health,
  output logic      [BYTE_W-1:0] rd_free,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic              we_health,
  input  wire logic              we_free,
  input  wire logic [BYTE_W-1:0] wd_health,
  input  wire logic [BYTE_W-1:0] wd_free
);

  logic [BYTE_W-1:0] health_mem [0:MAP_BYTES-1];
  logic [BYTE_W-1:0] free_mem   [0:MAP_BYTES-1];

  // Write either map, read both at the same byte
  always_ff @(posedge clk) begin
    if (we_health) begin
      health_mem[waddr] <= wd_health;
    end
    if (we_free) begin
      free_mem[waddr] <= wd_free;
    end
    rd_health <= health_mem[raddr];
    rd_free   <= free_mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/fbwpa_scan.sv
// Shared byte scanner: finds the first (or last) block in a range whose
// bitmap bits meet a predicate, one bitmap byte per cycle. Uses fbwpa_pkg.
`default_nettype none

module fbwpa_scan
  import fbwpa_pkg::*;
#(
  parameter int  NUM_BLOCKS = NUM_BLOCKS_DEF,
  localparam int BW         = $clog2(NUM_BLOCKS),
  localparam int AW         = BW - 3,
  localparam int XW         = BW + 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scan_cmd_t         cmd,
  input  wire logic [XW-1:0]     lo,
  input  wire logic [XW-1:0]     hi,
  input  wire logic [BYTE_W-1:0] rd_health,
  input  wire logic [BYTE_W-1:0] rd_free,
  output logic      [AW-1:0]     raddr,
  output scan_sts_t              sts,
  output logic      [BW-1:0]     blk
);

  logic          busy_r;
  logic          empty_r;
  logic          iss_r;
  logic          pend_r;
  logic          bwd_r;
  pred_t         pred_r;
  logic [BW-1:0] lo_r;
  logic [BW-1:0] hi_r;
  logic [AW-1:0] iaddr_r;
  logic [AW-1:0] last_addr_r;
  logic [AW-1:0] paddr_r;

  logic              empty_in;
  logic [BYTE_W-1:0] hit;
  logic [BYTE_W-1:0] mask;
  logic [BYTE_W-1:0] match;
  logic [2:0]        pos;
  logic              any;

  assign empty_in = $signed(lo) > $signed(hi);
  assign raddr    = iaddr_r;

  // Predicate over the byte that just came back
  always_comb begin
    unique case (pred_r)
      PRED_FREE:  hit = rd_free;
      PRED_USED:  hit = ~rd_free;
      PRED_VALID: hit = rd_health & rd_free;
      default:    hit = '0;
    endcase
  end

  // Trim the end bytes to the block range, then pick first or last hit
  always_comb begin
    for (int k = 0; k < BYTE_W; k++) begin
      mask[k] = (paddr_r != lo_r[BW-1:3] || 3'(k) >= lo_r[2:0]) &&
                (paddr_r != hi_r[BW-1:3] || 3'(k) <= hi_r[2:0]);
    end
    match = hit & mask;
    any   = |match;
    pos   = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (bwd_r) begin
        if (match[k]) pos = 3'(k);
      end else if (match[BYTE_W-1-k]) begin
        pos = 3'(BYTE_W-1-k);
      end
    end
  end

  assign sts.done  = busy_r && (empty_r || (pend_r && (any || paddr_r == last_addr_r)));
  assign sts.found = busy_r && !empty_r && pend_r && any;
  assign blk       = {paddr_r, pos};

  // Control: launch, issue one byte a cycle, stop on hit or range end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      empty_r <= 1'b0;
      iss_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else if (cmd.go) begin
      busy_r  <= 1'b1;
      empty_r <= empty_in;
      iss_r   <= !empty_in;
      pend_r  <= 1'b0;
    end else if (sts.done) begin
      busy_r <= 1'b0;
      iss_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= iss_r;
      if (iss_r && iaddr_r == last_addr_r) begin
        iss_r <= 1'b0;
      end
    end
  end

  // Payload: range, direction and byte addresses
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      bwd_r       <= cmd.bwd;
      pred_r      <= cmd.pred;
      lo_r        <= lo[BW-1:0];
      hi_r        <= hi[BW-1:0];
      iaddr_r     <= cmd.bwd ? hi[BW-1:3] : lo[BW-1:3];
      last_addr_r <= cmd.bwd ? lo[BW-1:3] : hi[BW-1:3];
    end else if (iss_r) begin
      paddr_r <= iaddr_r;
      if (iaddr_r != last_addr_r) begin
        iaddr_r <= bwd_r ? iaddr_r - AW'(1) : iaddr_r + AW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/fbwpa_checker.sv
// Port-level checks of the write-pointer allocator, bound to the top level.
// Depends only on the top level's ports and its PAGES_PER_BLOCK parameter.
`default_nettype none

module fbwpa_checker #(
  parameter int PAGES_PER_BLOCK = 64
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [11:0] out_write_block,
  input wire logic [5:0]  out_write_page,
  input wire logic [11:0] out_first_block,
  input wire logic [11:0] out_last_block,
  input wire logic        out_status
);

  // A waiting result holds still until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_write_block) &&
      $stable(out_write_page) && $stable(out_first_block) &&
      $stable(out_last_block) && $stable(out_status))
    else $error("result changed while stalled");

  // Reset leaves the block busy clearing and with no result
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready or result right after reset");

  // One item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken back to back");

  // Page stays inside the block
  a_page_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_write_page) < PAGES_PER_BLOCK)
    else $error("page beyond last page of block");

endmodule

bind flash_block_write_pointer_allocator fbwpa_checker #(
  .PAGES_PER_BLOCK(PAGES_PER_BLOCK)
) u_fbwpa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_write_block(out_write_block),
  .out_write_page (out_write_page),
  .out_first_block(out_first_block),
  .out_last_block (out_last_block),
  .out_status     (out_status)
);

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for flash_block_write_pointer_allocator: loads both bitmaps,
// then runs locate/open/append sequences against an in-bench predictor of the maps.
// Depends on fbwpa_pkg for field widths and function codes.

module tb;
  import fbwpa_pkg::*;

  localparam int          NBLK     = NUM_BLOCKS_DEF;
  localparam int          NRSV     = RESERVED_BLOCKS_DEF;
  localparam int          NPG      = PAGES_PER_BLOCK_DEF;
  localparam int          NBYTES   = (NBLK + 7) / 8;
  localparam int unsigned NO_BLOCK = 32'hFFFF_FFFF;
  localparam int          RAND_CMDS = 540;

  typedef struct packed {
    func_t             func;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] hb;
    logic [BYTE_W-1:0] wb;
  } alloc_cmd_t;

  typedef struct packed {
    logic [BLK_OUT_W-1:0]  blk;
    logic [PAGE_OUT_W-1:0] pg;
    logic [BLK_OUT_W-1:0]  first;
    logic [BLK_OUT_W-1:0]  last;
    logic                  st;
  } alloc_resp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     in_func = FN_LOAD;
  logic [IDX_W-1:0]      in_byte_index = '0;
  logic [BYTE_W-1:0]     in_health_byte = '0;
  logic [BYTE_W-1:0]     in_written_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BLK_OUT_W-1:0]  out_write_block;
  logic [PAGE_OUT_W-1:0] out_write_page;
  logic [BLK_OUT_W-1:0]  out_first_block;
  logic [BLK_OUT_W-1:0]  out_last_block;
  logic                  out_status;

  flash_block_write_pointer_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_byte_index   (in_byte_index),
    .in_health_byte  (in_health_byte),
    .in_written_byte (in_written_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_write_block (out_write_block),
    .out_write_page  (out_write_page),
    .out_first_block (out_first_block),
    .out_last_block  (out_last_block),
    .out_status      (out_status)
  );

  always #5 clk = ~clk;

  // Pending commands, expected responses and run statistics
  alloc_cmd_t  pending_cmds[$];
  alloc_resp_t want_resps[$];
  int          n_total = 0;
  int          n_accepted = 0;
  int          n_checked = 0;
  int          n_err = 0;
  int          n_func[4] = '{0, 0, 0, 0};
  int          n_moves = 0;
  int          n_status = 0;

  // Predicted allocator state
  bit [7:0]    good_map[NBYTES];
  bit [7:0]    avail_map[NBYTES];
  int unsigned region_first = 0;
  int unsigned region_last = 0;
  int unsigned ptr_block = 0;
  int unsigned ptr_page = 0;

  initial begin
    for (int i = 0; i < NBYTES; i++) begin
      good_map[i] = 8'h00;
      avail_map[i] = 8'hFF;
    end
  end

  function automatic bit blk_free(int unsigned b);
    if (b >= NBLK) return 1'b0;
    return avail_map[b >> 3][b & 7];
  endfunction

  function automatic bit blk_usable(int unsigned b);
    if (b >= NBLK) return 1'b0;
    return good_map[b >> 3][b & 7] && avail_map[b >> 3][b & 7];
  endfunction

  // Advance one block in circular order, skipping the reserved blocks
  function automatic int unsigned step_blk(int unsigned c);
    int unsigned n;
    n = c + 1;
    if (n >= NBLK || n < NRSV) return NRSV;
    return n;
  endfunction

  function automatic bit find_next_usable(input int unsigned s, output int unsigned hit);
    int unsigned c;
    c = s;
    hit = s;
    for (int k = 0; k < NBLK - NRSV; k++) begin
      c = step_blk(c);
      if (c == s) return 1'b0;
      if (blk_usable(c)) begin
        hit = c;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic int unsigned find_last_usable(int unsigned s);
    int unsigned c;
    int unsigned e;
    c = s;
    e = s;
    for (int k = 0; k < NBLK - NRSV; k++) begin
      c = step_blk(c);
      if (c == s) break;
      if (blk_usable(c)) e = c;
    end
    return e;
  endfunction

  // Find the start and end of the writable region and park the pointer at the start
  function automatic void locate_region();
    int unsigned bi;
    int unsigned nb;
    int          i;
    if (!blk_free(NBLK - 1)) begin
      bi = NRSV;
      while (bi < NBLK - 1 && !blk_free(bi)) bi++;
    end else begin
      i = NBLK - 1;
      while (i >= NRSV && blk_free(i)) i--;
      bi = (i < 0) ? NO_BLOCK : i;
      if (find_next_usable(bi, nb)) bi = nb;
      else if (bi == NO_BLOCK) bi = 0;
    end
    region_first = bi;
    region_last = find_last_usable(bi);
    ptr_block = region_first;
    ptr_page = 0;
  endfunction

  // Apply one command to the predicted state and return its response
  function automatic alloc_resp_t alloc_predict(alloc_cmd_t c);
    alloc_resp_t r;
    bit [7:0]    keep;
    int unsigned nb;
    int unsigned blk;
    int unsigned pg;
    bit          st;
    blk = ptr_block;
    pg = ptr_page;
    st = 1'b0;
    case (c.func)
      FN_LOAD: begin
        if (c.idx < NBYTES) begin
          for (int k = 0; k < 8; k++) keep[k] = (c.idx * 8 + k >= NRSV);
          good_map[c.idx] = c.hb;
          avail_map[c.idx] = ~(c.hb & c.wb & keep);
        end
      end
      FN_LOCATE: begin
        locate_region();
        blk = ptr_block;
        pg = ptr_page;
        st = (region_first == region_last);
      end
      default: begin
        if (c.func == FN_OPEN) begin
          if (ptr_block == region_last) st = 1'b1;
          else ptr_page = 0;
        end
        blk = ptr_block;
        pg = ptr_page;
        if (blk < NBLK) avail_map[blk >> 3][blk & 7] = 1'b0;
        // After the last page move on to the next usable block
        if (ptr_page >= NPG - 1) begin
          ptr_page = 0;
          if (find_next_usable(ptr_block, nb)) begin
            ptr_block = nb;
            n_moves++;
          end else begin
            st = 1'b1;
          end
        end else begin
          ptr_page++;
        end
      end
    endcase
    r.blk = blk[BLK_OUT_W-1:0];
    r.pg = pg[PAGE_OUT_W-1:0];
    r.first = region_first[BLK_OUT_W-1:0];
    r.last = region_last[BLK_OUT_W-1:0];
    r.st = st;
    return r;
  endfunction

  // Idle percentage for the current third of the run
  function automatic int idle_pct(bit rx);
    int ph;
    ph = (n_total > 0) ? n_accepted * 3 / n_total : 0;
    if (ph == 0) return rx ? 72 : 14;
    if (ph == 1) return rx ? 14 : 72;
    return 0;
  endfunction

  function automatic bit roll_idle(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  task automatic check_field(input string fld, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", fld, exp_v, act_v);
      n_err++;
    end
  endtask

  task automatic add_cmd(input func_t f, input int idx, input logic [7:0] hb,
                         input logic [7:0] wb);
    alloc_cmd_t c;
    c.func = f;
    c.idx = idx[IDX_W-1:0];
    c.hb = hb;
    c.wb = wb;
    pending_cmds.push_back(c);
  endtask

  // Present commands; predict each one as it is accepted
  always @(posedge clk) begin : drive_cmds
    alloc_cmd_t nxt;
    alloc_cmd_t cur;
    bit         took;
    if (rst_n) begin
      took = in_valid && in_ready;
      if (took) begin
        cur.func = func_t'(in_func);
        cur.idx = in_byte_index;
        cur.hb = in_health_byte;
        cur.wb = in_written_byte;
        want_resps.push_back(alloc_predict(cur));
        n_func[in_func]++;
        n_accepted++;
      end
      if (!in_valid || took) begin
        if (pending_cmds.size() > 0 && !roll_idle(idle_pct(1'b0))) begin
          nxt = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_func <= nxt.func;
          in_byte_index <= nxt.idx;
          in_health_byte <= nxt.hb;
          in_written_byte <= nxt.wb;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Compare each accepted response with the oldest prediction
  always @(posedge clk) begin : check_resps
    alloc_resp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (want_resps.size() == 0) begin
          $error("response with no command outstanding: block %0d page %0d",
                 out_write_block, out_write_page);
          n_err++;
        end else begin
          want = want_resps.pop_front();
          check_field("write_block", want.blk, out_write_block);
          check_field("write_page", want.pg, out_write_page);
          check_field("first_block", want.first, out_first_block);
          check_field("last_block", want.last, out_last_block);
          check_field("status", want.st, out_status);
          if (want.st) n_status++;
          n_checked++;
        end
      end
      out_ready <= !roll_idle(idle_pct(1'b1));
    end
  end

  // Build the command list, release reset and wait for the run to drain
  initial begin : stimulus
    bit [NBYTES-1:0] is_live;
    int              live_q[$];
    int              idx;
    int              n_rand;
    int              r;
    int              n_app;
    logic [7:0]      hb;
    logic [7:0]      wb;

    // Sparse map: a few live bytes hold usable blocks, the rest are used or bad
    is_live = '0;
    while (live_q.size() < 4) begin
      idx = $urandom_range(NBYTES - 2, 1);
      if (!is_live[idx]) begin
        is_live[idx] = 1'b1;
        live_q.push_back(idx);
      end
    end
    for (int i = 0; i < NBYTES; i++) begin
      if (is_live[i]) begin
        hb = $urandom | 8'h11;
        wb = $urandom & ~hb;
      end else begin
        hb = $urandom;
        wb = hb | $urandom;
      end
      add_cmd(FN_LOAD, i, hb, wb);
    end

    // Directed: reserved byte, last block used, then free
    add_cmd(FN_LOAD, 0, 8'hFF, 8'hFF);
    add_cmd(FN_LOAD, NBYTES - 1, 8'hFF, 8'hFF);
    add_cmd(FN_LOCATE, 0, 8'h00, 8'h00);
    add_cmd(FN_OPEN, 0, 8'h00, 8'h00);
    add_cmd(FN_APPEND, 0, 8'h00, 8'h00);
    add_cmd(FN_LOAD, NBYTES - 1, 8'h00, 8'h00);
    add_cmd(FN_LOCATE, 0, 8'h00, 8'h00);
    add_cmd(FN_OPEN, 0, 8'h00, 8'h00);
    // Directed: no usable block left anywhere, open out of space
    foreach (live_q[i]) add_cmd(FN_LOAD, live_q[i], 8'h00, $urandom);
    add_cmd(FN_LOCATE, 0, 8'h00, 8'h00);
    add_cmd(FN_OPEN, 0, 8'h00, 8'h00);
    add_cmd(FN_APPEND, 0, 8'h00, 8'h00);
    // Directed: one usable block, start equals end
    add_cmd(FN_LOAD, live_q[0], 8'h08, 8'hF7);
    add_cmd(FN_LOCATE, 0, 8'h00, 8'h00);
    add_cmd(FN_OPEN, 0, 8'h00, 8'h00);
    add_cmd(FN_APPEND, 0, 8'h00, 8'h00);
    // Directed: last byte fully usable
    add_cmd(FN_LOAD, NBYTES - 1, 8'hFF, 8'h00);
    add_cmd(FN_LOCATE, 0, 8'h00, 8'h00);
    add_cmd(FN_OPEN, 0, 8'h00, 8'h00);
    add_cmd(FN_APPEND, 0, 8'h00, 8'h00);

    // Random sessions: map edits, locate, open, runs of appends
    live_q.delete();
    n_rand = 0;
    while (n_rand < RAND_CMDS) begin
      repeat ($urandom_range(3, 0)) begin
        r = $urandom_range(99, 0);
        hb = $urandom;
        wb = $urandom;
        if (r < 35) begin
          idx = $urandom_range(NBYTES - 2, 1);
          live_q.push_back(idx);
        end else if (r < 65) begin
          idx = $urandom_range(NBYTES - 1, 0);
          wb = hb | wb;
        end else if (r < 80) begin
          idx = (live_q.size() > 0) ? live_q.pop_front() : $urandom_range(NBYTES - 1, 0);
          wb = hb | wb;
        end else if (r < 92) begin
          idx = $urandom_range(NBYTES - 1, 0);
        end else begin
          idx = NBYTES - 1;
        end
        add_cmd(FN_LOAD, idx, hb, wb);
        n_rand++;
      end
      if ($urandom_range(99, 0) < 85) begin
        add_cmd(FN_LOCATE, $urandom, $urandom, $urandom);
        n_rand++;
      end
      if ($urandom_range(99, 0) < 90) begin
        add_cmd(FN_OPEN, $urandom, $urandom, $urandom);
        n_rand++;
      end
      n_app = ($urandom_range(99, 0) < 40) ? $urandom_range(200, 64) : $urandom_range(20, 0);
      repeat (n_app) begin
        if ($urandom_range(99, 0) < 5) add_cmd(FN_OPEN, $urandom, $urandom, $urandom);
        else add_cmd(FN_APPEND, $urandom, $urandom, $urandom);
        n_rand++;
      end
    end
    n_total = pending_cmds.size();

    // Hold reset, then let the bench run until everything is back
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_cmds.size() > 0 || in_valid || want_resps.size() > 0) @(posedge clk);
    repeat (1600) @(posedge clk);

    $display("Checked %0d responses for %0d commands: %0d loads, %0d locates, %0d opens, %0d appends.",
             n_checked, n_accepted, n_func[FN_LOAD], n_func[FN_LOCATE], n_func[FN_OPEN],
             n_func[FN_APPEND]);
    $display("Write pointer moved to a new block %0d times; %0d responses carried status set.",
             n_moves, n_status);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #60_000_000;
    $error("timeout: %0d commands pending, %0d responses outstanding",
           pending_cmds.size(), want_resps.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/fbwpa_pkg.sv
rtl/fbwpa_maps.sv
rtl/fbwpa_scan.sv
rtl/flash_block_write_pointer_allocator.sv
rtl/fbwpa_checker.sv
bench/tb.sv
